// ----- rtl/core/sj3e_pkg.sv -----
package sj3e_pkg;

  typedef struct packed {
    logic signed [31:0] diag_x;
    logic signed [31:0] diag_y;
    logic signed [31:0] diag_z;
    logic signed [31:0] off_xy;
    logic signed [31:0] off_xz;
    logic signed [31:0] off_yz;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] eigenvalue;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [1:0]         rank;
    logic               last;
  } out_req_t;

  localparam logic [0:0] REG_THRESHOLD = 1'd0;
  localparam logic [0:0] REG_SWEEPS    = 1'd1;
  localparam int CFG_W = 16;

  localparam int CORDIC_STEPS = 31;
  localparam logic signed [63:0] ANG_HALF_PI = 64'sd1686629713;
  localparam logic signed [63:0] GAIN_INV    = 64'sd652032874;
  localparam logic signed [63:0] MAT_LIMIT   = 64'sd68719476736;
  localparam logic signed [63:0] VEC_LIMIT   = 64'sd4294967296;
  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;

  function automatic logic signed [63:0] atan_lut(input logic [4:0] i);
    logic signed [63:0] r;
    case (i)
      5'd0: r = 64'sd843314857;
      5'd1: r = 64'sd497837829;
      5'd2: r = 64'sd263043837;
      5'd3: r = 64'sd133525159;
      5'd4: r = 64'sd67021687;
      5'd5: r = 64'sd33543516;
      5'd6: r = 64'sd16775851;
      5'd7: r = 64'sd8388437;
      5'd8: r = 64'sd4194283;
      5'd9: r = 64'sd2097149;
      default: r = 64'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] clampv(input logic signed [63:0] v,
                                                input logic signed [63:0] lim);
    logic signed [63:0] r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

// ----- rtl/core/sj3e_front.sv -----
module sj3e_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              ready,
  input  sj3e_pkg::in_req_t data,
  output logic              q_valid,
  input  logic              q_ready,
  output sj3e_pkg::in_req_t q_data
);

  // two-entry queue between intake and solver
  sj3e_pkg::in_req_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign ready   = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = mem[rd_ptr];
  assign push    = valid && ready;
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop from empty queue");

endmodule

// ----- rtl/core/sj3e_back.sv -----
module sj3e_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sj3e_pkg::in_req_t  in_data,
  input  logic [15:0]        threshold,
  input  logic [5:0]         sweeps,
  output logic               valid,
  input  logic               ready,
  output sj3e_pkg::out_req_t data
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_TEST  = 11'b00000000010,
    S_NORM  = 11'b00000000100,
    S_VEC   = 11'b00000001000,
    S_ROT   = 11'b00000010000,
    S_MUL1  = 11'b00000100000,
    S_MUL2  = 11'b00001000000,
    S_MUL3  = 11'b00010000000,
    S_SORT  = 11'b00100000000,
    S_EMIT  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;
  logic signed [63:0] a00, a11, a22, a01, a02, a12;
  logic signed [63:0] v [3][3];
  logic [5:0] iter;
  logic [1:0] p, q;
  logic signed [63:0] cx, cy, cz;
  logic [4:0] step;
  logic signed [63:0] cc, ss, c2, s2, cs2;
  logic signed [63:0] ev [3];
  logic [1:0] col [3];
  logic [1:0] si, sj, k;
  logic [2:0] mstep;

  // shared q30 multiplier, operands chosen by the sequencer
  // operand magnitudes stay below 2^37 and coefficients below 2^32
  logic signed [63:0] ma, mc, mres;
  always_comb begin
    logic neg;
    logic [63:0] am, cm, r;
    logic [16:0] ah;
    logic [19:0] al;
    logic [31:0] cw;
    logic [48:0] ph;
    logic [51:0] pl;
    logic [52:0] t;
    neg = (ma < 0) != (mc < 0);
    am = sj3e_pkg::mag64(ma);
    cm = sj3e_pkg::mag64(mc);
    ah = am[36:20];
    al = am[19:0];
    cw = cm[31:0];
    ph = ah * cw;
    pl = al * cw;
    t = 53'(pl) + 53'({ph[9:0], 20'd0}) + (53'd1 << 29);
    r = 64'(ph[48:10]) + 64'(t[52:30]);
    mres = neg ? -$signed(r) : $signed(r);
  end

  // pivot selection
  logic [63:0] m01, m02, m12;
  logic [1:0] np, nq;
  logic signed [63:0] app, aqq, apq, arp, arq;
  assign m01 = sj3e_pkg::mag64(a01);
  assign m02 = sj3e_pkg::mag64(a02);
  assign m12 = sj3e_pkg::mag64(a12);
  always_comb begin
    logic [63:0] best;
    np = 2'd0; nq = 2'd1; best = m01;
    if (m02 > best) begin np = 2'd0; nq = 2'd2; best = m02; end
    if (m12 > best) begin np = 2'd1; nq = 2'd2; end
  end
  always_comb begin
    app = (p == 2'd0) ? a00 : a11;
    aqq = (q == 2'd1) ? a11 : a22;
    apq = (p == 2'd1) ? a12 : ((q == 2'd1) ? a01 : a02);
    arp = (p == 2'd1) ? a01 : ((q == 2'd1) ? a02 : a01);
    arq = (p == 2'd1) ? a02 : ((q == 2'd1) ? a12 : a12);
  end

  // partial product scratch for the rotation
  logic signed [63:0] acc0, acc1;
  logic [1:0] vr;
  logic signed [63:0] vip, viq;
  assign vip = v[vr][p];
  assign viq = v[vr][q];

  always_comb begin
    ma = 64'sd0; mc = 64'sd0;
    case (mstep)
      3'd1: begin ma = cc; mc = cc; end
      3'd2: begin ma = ss; mc = ss; end
      3'd3: begin ma = cc; mc = ss; end
      default: begin ma = 64'sd0; mc = 64'sd0; end
    endcase
    if (state == S_MUL2) begin
      case (mstep)
        3'd0: begin ma = arp; mc = cc; end
        3'd1: begin ma = arq; mc = ss; end
        3'd2: begin ma = arp; mc = ss; end
        3'd3: begin ma = arq; mc = cc; end
        3'd4: begin ma = app; mc = c2; end
        3'd5: begin ma = aqq; mc = s2; end
        3'd6: begin ma = apq; mc = cs2; end
        default: begin ma = app; mc = s2; end
      endcase
    end else if (state == S_MUL3) begin
      case (mstep)
        3'd0: begin ma = aqq; mc = c2; end
        3'd1: begin ma = apq; mc = cs2; end
        3'd2: begin ma = vip; mc = cc; end
        3'd3: begin ma = viq; mc = ss; end
        3'd4: begin ma = vip; mc = ss; end
        default: begin ma = viq; mc = cc; end
      endcase
    end
  end

  logic signed [63:0] sh_x, sh_y;
  assign sh_x = cx >>> step;
  assign sh_y = cy >>> step;
  logic [63:0] offsum;
  assign offsum = m01 + m02 + m12;

  logic signed [63:0] t0, t1;
  logic signed [63:0] new_rp, new_rq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      step  <= 5'd0;
      cz    <= 64'sd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            a00 <= 64'(in_data.diag_x); a11 <= 64'(in_data.diag_y);
            a22 <= 64'(in_data.diag_z); a01 <= 64'(in_data.off_xy);
            a02 <= 64'(in_data.off_xz); a12 <= 64'(in_data.off_yz);
            for (int i = 0; i < 3; i++)
              for (int j = 0; j < 3; j++)
                v[i][j] <= (i == j) ? sj3e_pkg::ONE_Q30 : 64'sd0;
            iter <= 6'd0;
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (iter == sweeps || $signed(offsum) < $signed({48'd0, threshold})) begin
            ev[0] <= a00; ev[1] <= a11; ev[2] <= a22;
            col[0] <= 2'd0; col[1] <= 2'd1; col[2] <= 2'd2;
            si <= 2'd0; sj <= 2'd1;
            state <= S_SORT;
          end else begin
            p <= np; q <= nq;
            step <= 5'd0; cz <= 64'sd0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // vector start: y = 2apq, x = aqq-app, scaled up one bit a cycle
          if (step == 5'd0 && cz == 64'sd0) begin
            cy <= apq <<< 1; cx <= aqq - app; cz <= 64'sd1;
          end else if (cx == 64'sd0 && cy == 64'sd0) begin
            // degenerate angle, rotate by zero
            cz <= 64'sd0; step <= 5'd31; state <= S_ROT;
          end else if ((sj3e_pkg::mag64(cx) > sj3e_pkg::mag64(cy) ?
                        sj3e_pkg::mag64(cx) : sj3e_pkg::mag64(cy)) < (64'd1 << 40)) begin
            cx <= cx <<< 1; cy <= cy <<< 1;
          end else begin
            if (cx < 0) begin
              if (cy >= 0) begin cx <= cy; cy <= -cx; cz <= sj3e_pkg::ANG_HALF_PI; end
              else begin cx <= -cy; cy <= cx; cz <= -sj3e_pkg::ANG_HALF_PI; end
            end else cz <= 64'sd0;
            step <= 5'd0;
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (cy >= 0) begin
            cx <= cx + sh_y; cy <= cy - sh_x; cz <= cz + sj3e_pkg::atan_lut(step);
          end else begin
            cx <= cx - sh_y; cy <= cy + sh_x; cz <= cz - sj3e_pkg::atan_lut(step);
          end
          if (step == 5'(sj3e_pkg::CORDIC_STEPS - 1)) begin
            step <= 5'd31;
            state <= S_ROT;
          end else step <= step + 5'd1;
        end
        S_ROT: begin
          if (step == 5'd31) begin
            // load rotation: z = theta = angle/2
            cz <= cz >>> 1; cx <= sj3e_pkg::GAIN_INV; cy <= 64'sd0; step <= 5'd0;
          end else begin
            if (cz >= 0) begin
              cx <= cx - sh_y; cy <= cy + sh_x; cz <= cz - sj3e_pkg::atan_lut(step);
            end else begin
              cx <= cx + sh_y; cy <= cy - sh_x; cz <= cz + sj3e_pkg::atan_lut(step);
            end
            if (step == 5'(sj3e_pkg::CORDIC_STEPS - 1)) begin
              mstep <= 3'd0; state <= S_MUL1;
            end else step <= step + 5'd1;
          end
        end
        S_MUL1: begin
          case (mstep)
            3'd0: begin cc <= cx; ss <= cy; end
            3'd1: c2 <= mres;
            3'd2: s2 <= mres;
            default: cs2 <= mres <<< 1;
          endcase
          if (mstep == 3'd3) begin mstep <= 3'd0; state <= S_MUL2; end
          else mstep <= mstep + 3'd1;
        end
        S_MUL2: begin
          case (mstep)
            3'd0: t0 <= mres;
            3'd1: new_rp <= sj3e_pkg::clampv(t0 - mres, sj3e_pkg::MAT_LIMIT);
            3'd2: t0 <= mres;
            3'd3: new_rq <= sj3e_pkg::clampv(t0 + mres, sj3e_pkg::MAT_LIMIT);
            3'd4: t1 <= mres;
            3'd5: t1 <= t1 + mres;
            3'd6: t1 <= sj3e_pkg::clampv(t1 - mres, sj3e_pkg::MAT_LIMIT);
            default: t0 <= mres;
          endcase
          if (mstep == 3'd7) begin mstep <= 3'd0; state <= S_MUL3; end
          else mstep <= mstep + 3'd1;
        end
        S_MUL3: begin
          case (mstep)
            3'd0: t0 <= t0 + mres;
            3'd1: begin
              // commit matrix update
              if (p == 2'd0) a00 <= t1; else a11 <= t1;
              if (q == 2'd1) a11 <= sj3e_pkg::clampv(t0 + mres, sj3e_pkg::MAT_LIMIT);
              else a22 <= sj3e_pkg::clampv(t0 + mres, sj3e_pkg::MAT_LIMIT);
              if (p == 2'd1) begin a12 <= 64'sd0; a01 <= new_rp; a02 <= new_rq; end
              else if (q == 2'd1) begin a01 <= 64'sd0; a02 <= new_rp; a12 <= new_rq; end
              else begin a02 <= 64'sd0; a01 <= new_rp; a12 <= new_rq; end
              vr <= 2'd0;
            end
            3'd2: acc0 <= mres;
            3'd3: acc0 <= sj3e_pkg::clampv(acc0 - mres, sj3e_pkg::VEC_LIMIT);
            3'd4: acc1 <= mres;
            default: begin
              v[vr][p] <= acc0;
              v[vr][q] <= sj3e_pkg::clampv(acc1 + mres, sj3e_pkg::VEC_LIMIT);
            end
          endcase
          if (mstep == 3'd5) begin
            if (vr == 2'd2) begin iter <= iter + 6'd1; state <= S_TEST; end
            else begin vr <= vr + 2'd1; mstep <= 3'd2; end
          end else mstep <= mstep + 3'd1;
        end
        S_SORT: begin
          if (ev[si] < ev[sj]) begin
            ev[si] <= ev[sj]; ev[sj] <= ev[si];
            col[si] <= col[sj]; col[sj] <= col[si];
          end
          if (sj == 2'd2) begin
            if (si == 2'd1) begin k <= 2'd0; state <= S_EMIT; end
            else begin si <= 2'd1; sj <= 2'd2; end
          end else sj <= sj + 2'd1;
        end
        S_EMIT: begin
          if (!valid || ready) begin
            data.eigenvalue <= 32'(sj3e_pkg::clampv(ev[k], 64'sh7FFFFFFF) < -64'sh80000000 ?
                               -64'sh80000000 : (ev[k] < -64'sh80000000 ? -64'sh80000000 :
                               sj3e_pkg::clampv(ev[k], 64'sh7FFFFFFF)));
            data.vec_x <= 32'(sj3e_pkg::clampv(v[0][col[k]], sj3e_pkg::ONE_Q30));
            data.vec_y <= 32'(sj3e_pkg::clampv(v[1][col[k]], sj3e_pkg::ONE_Q30));
            data.vec_z <= 32'(sj3e_pkg::clampv(v[2][col[k]], sj3e_pkg::ONE_Q30));
            data.rank <= k;
            data.last <= (k == 2'd2);
            valid <= 1'b1;
            if (k == 2'd2) state <= S_DONE;
            else k <= k + 2'd1;
          end
        end
        S_DONE: begin
          if (ready) begin valid <= 1'b0; state <= S_IDLE; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("accept while busy");
  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    valid && data.last |-> data.rank == 2'd2) else $error("last without rank 2");

endmodule

// ----- rtl/core/symmetric_3x3_jacobi_eigen_top.sv -----
// Jacobi eigen solver for one symmetric 3x3 Q16.16 matrix per request. Each
// request yields three result requests, largest eigenvalue first, with unit
// eigenvectors in Q2.30; the third carries last. A two-deep input queue
// takes requests while the solver works. Each rotation runs a sweep test, a
// normalize, a 31-step vectoring CORDIC, a sine-cosine CORDIC and 25
// multiplies on one shared multiplier plus a latch step.
module symmetric_3x3_jacobi_eigen_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sj3e_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sj3e_pkg::out_req_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // configuration registers
  logic [15:0] threshold;
  logic [5:0]  sweeps;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'd1;
      sweeps    <= 6'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        sj3e_pkg::REG_THRESHOLD: threshold <= cfg_data;
        sj3e_pkg::REG_SWEEPS:    sweeps <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // queue between intake and solver
  logic              q_valid;
  logic              q_ready;
  sj3e_pkg::in_req_t q_data;

  sj3e_front u_front (
    .clk(clk), .rst(rst),
    .valid(in_valid), .ready(in_ready), .data(in_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  sj3e_back u_back (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .threshold(threshold), .sweeps(sweeps),
    .valid(out_valid), .ready(out_ready), .data(out_data)
  );

endmodule

// ----- bench/tb.sv -----
module tb;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sj3e_pkg::in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sj3e_pkg::out_req_t out_data;
  logic     cfg_we = 1'b0;
  logic [0:0]  cfg_index = sj3e_pkg::REG_THRESHOLD;
  logic [15:0] cfg_data = '0;

  always #2 clk = ~clk;

  symmetric_3x3_jacobi_eigen_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // angle table for both cordic passes, radians scaled by 2^30
  localparam longint ATAN_TAB [31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  // predictor copy of the two registers
  longint   thresh_q;
  int       sweep_limit;
  sj3e_pkg::out_req_t eigenpair_q[$];
  int       errors = 0;
  int       pairs_seen = 0;
  int       matrices_sent = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;

  function automatic longint fshr(longint v, int n);
    return v >>> n;  // arithmetic shift is a floor shift
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint lim(longint v, longint l);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  // product with a q2.30 coefficient, round half away from zero
  function automatic longint mulq30(longint a, longint c);
    bit neg;
    logic [127:0] p;
    longint r;
    neg = (a < 0) != (c < 0);
    p = 128'(absl(a)) * 128'(absl(c)) + (128'd1 << 29);
    r = longint'(p >> 30);
    return neg ? -r : r;
  endfunction

  function automatic longint atan2_q30(longint y, longint x);
    longint z, t, nx, ny, m;
    z = 0;
    if (x == 0 && y == 0) return 0;
    m = absl(x) > absl(y) ? absl(x) : absl(y);
    while (m < (64'sd1 << 40)) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = sj3e_pkg::ANG_HALF_PI;
      end else begin
        x = -y; y = t; z = -sj3e_pkg::ANG_HALF_PI;
      end
    end
    for (int i = 0; i < 31; i++) begin
      if (y >= 0) begin
        nx = x + fshr(y, i); ny = y - fshr(x, i); z += ATAN_TAB[i];
      end else begin
        nx = x - fshr(y, i); ny = y + fshr(x, i); z -= ATAN_TAB[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  task automatic cordic_sincos(input longint th, output longint c, output longint s);
    longint x, y, z, nx, ny;
    x = sj3e_pkg::GAIN_INV; y = 0; z = th;
    for (int i = 0; i < 31; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i); ny = y + fshr(x, i); z -= ATAN_TAB[i];
      end else begin
        nx = x + fshr(y, i); ny = y - fshr(x, i); z += ATAN_TAB[i];
      end
      x = nx; y = ny;
    end
    c = x; s = y;
  endtask

  // full jacobi solve, pushes three sorted eigenpairs
  task automatic predict_eigenpairs(input sj3e_pkg::in_req_t m);
    longint a[3][3], v[3][3], ev[3];
    longint c, s, c2, s2, cs2, app, aqq, apq, aip, aiq, best, vip, viq, t, e;
    int p, q, r;
    sj3e_pkg::out_req_t o;
    a[0][0] = m.diag_x; a[1][1] = m.diag_y; a[2][2] = m.diag_z;
    a[0][1] = m.off_xy; a[1][0] = m.off_xy;
    a[0][2] = m.off_xz; a[2][0] = m.off_xz;
    a[1][2] = m.off_yz; a[2][1] = m.off_yz;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        v[i][j] = (i == j) ? sj3e_pkg::ONE_Q30 : 0;
    for (int it = 0; it < sweep_limit; it++) begin
      if (absl(a[0][1]) + absl(a[0][2]) + absl(a[1][2]) < thresh_q) break;
      p = 0; q = 1; best = absl(a[0][1]);
      if (absl(a[0][2]) > best) begin
        q = 2; best = absl(a[0][2]);
      end
      if (absl(a[1][2]) > best) begin
        p = 1; q = 2;
      end
      r = 3 - p - q;
      app = a[p][p]; aqq = a[q][q]; apq = a[p][q];
      cordic_sincos(fshr(atan2_q30(2 * apq, aqq - app), 1), c, s);
      aip = a[r][p]; aiq = a[r][q];
      a[r][p] = lim(mulq30(aip, c) - mulq30(aiq, s), sj3e_pkg::MAT_LIMIT);
      a[p][r] = a[r][p];
      a[r][q] = lim(mulq30(aip, s) + mulq30(aiq, c), sj3e_pkg::MAT_LIMIT);
      a[q][r] = a[r][q];
      c2 = mulq30(c, c); s2 = mulq30(s, s); cs2 = 2 * mulq30(c, s);
      a[p][p] = lim(mulq30(app, c2) + mulq30(aqq, s2) - mulq30(apq, cs2),
                    sj3e_pkg::MAT_LIMIT);
      a[q][q] = lim(mulq30(app, s2) + mulq30(aqq, c2) + mulq30(apq, cs2),
                    sj3e_pkg::MAT_LIMIT);
      a[p][q] = 0; a[q][p] = 0;
      for (int i = 0; i < 3; i++) begin
        vip = v[i][p]; viq = v[i][q];
        v[i][p] = lim(mulq30(vip, c) - mulq30(viq, s), sj3e_pkg::VEC_LIMIT);
        v[i][q] = lim(mulq30(vip, s) + mulq30(viq, c), sj3e_pkg::VEC_LIMIT);
      end
    end
    for (int i = 0; i < 3; i++) ev[i] = a[i][i];
    // exchange sort, ties stay put
    for (int i = 0; i < 2; i++)
      for (int j = i + 1; j < 3; j++)
        if (ev[i] < ev[j]) begin
          t = ev[i]; ev[i] = ev[j]; ev[j] = t;
          for (int k = 0; k < 3; k++) begin
            t = v[k][i]; v[k][i] = v[k][j]; v[k][j] = t;
          end
        end
    for (int k = 0; k < 3; k++) begin
      // symmetric clamp first, only values below -2^31 pin to the floor
      e = lim(ev[k], 64'sh7FFFFFFF);
      if (ev[k] < -64'sh80000000) e = -64'sh80000000;
      o.eigenvalue = 32'(e);
      o.vec_x = 32'(lim(v[0][k], sj3e_pkg::ONE_Q30));
      o.vec_y = 32'(lim(v[1][k], sj3e_pkg::ONE_Q30));
      o.vec_z = 32'(lim(v[2][k], sj3e_pkg::ONE_Q30));
      o.rank = 2'(k);
      o.last = (k == 2);
      eigenpair_q.push_back(o);
    end
  endtask

  // register write, only while nothing is in flight
  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sj3e_pkg::REG_THRESHOLD) thresh_q = val;
    else sweep_limit = val[5:0];
    @(posedge clk);
  endtask

  task automatic send_matrix(input sj3e_pkg::in_req_t m);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_data <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_eigenpairs(m);
    matrices_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (eigenpair_q.size() != 0) @(posedge clk);
    // solver may still be busy with nothing left to show; let it settle
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_entry(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
      default: return 32'($signed($urandom_range(0, 32'h7FF)) - 32'sh400);
    endcase
  endfunction

  // receiver: random stall, checks each accepted result against the oldest pair
  always @(posedge clk) begin
    out_ready <= !(snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct);
    if (!rst && out_valid && out_ready) begin
      pairs_seen++;
      if (eigenpair_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        errors++;
      end else begin
        sj3e_pkg::out_req_t w;
        w = eigenpair_q.pop_front();
        if (out_data !== w) begin
          $display("%0t mismatch expected %p actual %p", $time, w, out_data);
          errors++;
        end
      end
    end
  end

  // directed rows: first three carry a hand-derived result for the trivial cases
  localparam int NDIR = 14;
  sj3e_pkg::in_req_t dir_rows[NDIR];
  bit      dir_typed[NDIR];
  sj3e_pkg::in_req_t r;

  initial begin
    thresh_q = 1; sweep_limit = 50;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // already diagonal and descending: identity columns out, no rotation
    dir_rows[0] = '{32'sh30000, 32'sh20000, 32'sh10000, 0, 0, 0};
    dir_rows[1] = '{32'sh7FFFFFFF, 0, 32'sh80000000, 0, 0, 0};
    dir_rows[2] = '{0, 0, 0, 0, 0, 0};
    dir_rows[3] = '{32'sh10000, 32'sh10000, 0, 32'sh10000, 0, 0};
    dir_rows[4] = '{32'sh20000, 32'sh10000, 32'sh30000, 32'sh8000, 32'sh8000, 32'sh8000};
    dir_rows[5] = '{0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
    dir_rows[6] = '{32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh80000000, 32'sh1, 32'shFFFFFFFF};
    dir_rows[7] = '{32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF,
                    -32'sh10000, -32'sh10000, -32'sh10000};
    dir_rows[8] = '{32'sh50000, 0, 32'shFFFB0000, 0, 32'sh20000, 0};
    dir_rows[9] = '{0, 32'sh40000, 0, 0, 0, 32'shFFFF0000};
    dir_rows[10] = '{32'sh55555555, 32'shAAAAAAAA, 32'sh12345678,
                     32'sh0F0F0F0F, 32'shF0F0F0F0, 32'h3C3C3C3C};
    dir_rows[11] = '{32'shAAAAAAAA, 32'sh55555555, 32'shEDCBA987,
                     32'shF0F0F0F0, 32'sh0F0F0F0F, 32'shC3C3C3C3};
    dir_rows[12] = '{1, 2, 3, 1, 1, 1};
    dir_rows[13] = '{32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0};
    dir_typed = '{1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    for (int i = 0; i < NDIR; i++) begin
      if (dir_typed[i]) begin
        // hand check of the trivial rows on top of the predictor
        predict_eigenpairs(dir_rows[i]);
        if (eigenpair_q[$].vec_z !== sj3e_pkg::ONE_Q30[31:0] ||
            eigenpair_q[$-2].vec_x !== sj3e_pkg::ONE_Q30[31:0]) begin
          $display("%0t mismatch expected identity columns actual %p", $time, eigenpair_q[$]);
          errors++;
        end
        repeat (3) void'(eigenpair_q.pop_back());
      end
      send_matrix(dir_rows[i]);
    end
    drain();

    // special settings: zero sweeps, zero threshold, widest threshold, one sweep
    write_reg(sj3e_pkg::REG_SWEEPS, 16'd0);
    send_matrix(dir_rows[4]); send_matrix(dir_rows[5]);
    drain();
    write_reg(sj3e_pkg::REG_THRESHOLD, 16'd0); write_reg(sj3e_pkg::REG_SWEEPS, 16'd63);
    send_matrix(dir_rows[4]); send_matrix(dir_rows[13]);
    drain();
    write_reg(sj3e_pkg::REG_THRESHOLD, 16'hFFFF); write_reg(sj3e_pkg::REG_SWEEPS, 16'd1);
    send_matrix(dir_rows[10]); send_matrix(dir_rows[8]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = ph == 0 ? 35 : ph == 1 ? 72 : 0;
      snk_idle_pct = ph == 0 ? 72 : ph == 1 ? 35 : 0;
      write_reg(sj3e_pkg::REG_THRESHOLD, 16'($urandom_range(0, 300)));
      write_reg(sj3e_pkg::REG_SWEEPS, 16'($urandom_range(0, 63)));
      for (int n = 0; n < 80; n++) begin
        int kind;
        kind = $urandom_range(0, 2);
        r.diag_x = rand_entry(kind); r.diag_y = rand_entry(kind);
        r.diag_z = rand_entry(kind); r.off_xy = rand_entry(kind);
        r.off_xz = rand_entry(kind); r.off_yz = rand_entry(kind);
        send_matrix(r);
        // hold off once per phase until every pair is back
        if (n == 40) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (eigenpair_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    write_reg(sj3e_pkg::REG_THRESHOLD, 16'd1); write_reg(sj3e_pkg::REG_SWEEPS, 16'd50);
    send_matrix(dir_rows[10]);
    drain();

    $display("tb: %0d matrices, %0d eigenpairs checked over several register settings",
             matrices_sent, pairs_seen);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog: roughly 260 matrices at their longest solve, about ten times over
  initial begin
    #100000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sj3e_pkg.sv
rtl/core/sj3e_front.sv
rtl/core/sj3e_back.sv
rtl/core/symmetric_3x3_jacobi_eigen_top.sv
bench/tb.sv
